FILE: rtl/core/xmad_pkg.sv
// Types, constants and decode helpers for the x86 memory-move decoder.
`timescale 1ns / 1ps
`default_nettype none

package xmad_pkg;

    // Longest legal instruction in bytes
    localparam int unsigned MAX_INSTR_BYTES = 15;
    localparam int unsigned COUNT_W         = 4;

    // Prefix bytes that are skipped
    localparam logic [7:0] PFX_ES        = 8'h26;
    localparam logic [7:0] PFX_CS        = 8'h2e;
    localparam logic [7:0] PFX_SS        = 8'h36;
    localparam logic [7:0] PFX_DS        = 8'h3e;
    localparam logic [7:0] PFX_FS        = 8'h64;
    localparam logic [7:0] PFX_GS        = 8'h65;
    localparam logic [7:0] PFX_OPSIZE    = 8'h66;
    localparam logic [7:0] PFX_ADDRSIZE  = 8'h67;

    // Opcodes
    localparam logic [7:0] OPC_ESCAPE    = 8'h0f;
    localparam logic [7:0] OPC_MOV_FIRST = 8'h88;
    localparam logic [7:0] OPC_MOV_LAST  = 8'h8c;
    localparam logic [7:0] OPC_MOV_IMM8  = 8'hc6;
    localparam logic [7:0] OPC_MOV_IMM   = 8'hc7;

    localparam logic [7:0] MODRM_REG_MASK = 8'b00111000;

    // Operand lengths in bytes
    localparam logic [2:0] LEN_BYTE  = 3'd1;
    localparam logic [2:0] LEN_WORD  = 3'd2;
    localparam logic [2:0] LEN_DWORD = 3'd4;

    // Register code for the immediate form (-1)
    localparam logic signed [3:0] REG_IMMEDIATE = -4'sd1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_OPCODE   = 3'd1,
        ST_TWO_BYTE    = 3'd2,
        ST_UNSUPPORTED = 3'd3,
        ST_LENGTH      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'b001,
        PH_MODRM  = 3'b010,
        PH_TAIL   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] instr_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic signed [3:0] dest_register;
        logic [2:0]        operand_bytes;
        logic [31:0]       immediate_value;
        logic [2:0]        status;
    } out_beat_t;

    function automatic logic is_skip_byte(input logic [7:0] b);
        return (b == PFX_ES) || (b == PFX_CS) || (b == PFX_SS) || (b == PFX_DS) ||
               (b == PFX_FS) || (b == PFX_GS) || (b == PFX_OPSIZE) ||
               (b == PFX_ADDRSIZE);
    endfunction

    function automatic logic is_reg_form(input logic [7:0] op);
        return (op >= OPC_MOV_FIRST) && (op <= OPC_MOV_LAST);
    endfunction

    function automatic logic is_imm_form(input logic [7:0] op);
        return (op == OPC_MOV_IMM8) || (op == OPC_MOV_IMM);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/x86_mov_access_decoder.sv
// Top level: byte-serial x86 move decoder with a registered result.
`timescale 1ns / 1ps
`default_nettype none

// Takes one instruction byte per beat on the item channel and returns one
// result beat per instruction, in the cycle after the byte marked last. A new
// byte is taken in every cycle while the result register is empty or being
// drained, so the sustained rate is one byte per clock; the only stall is a
// result beat held by result_ready low. The parser state registers hold the
// progress through prefix, opcode, ModRM and trailing bytes; the result is
// worked out from that state and the last byte in a single pass. A nonzero
// status returns zero in every other field.
module x86_mov_access_decoder
    import xmad_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_ready,
    input  wire in_beat_t  item,
    output logic           result_valid,
    input  wire logic      result_ready,
    output out_beat_t      result
);

    // Parser state
    phase_t             phase_reg,    phase_next;
    logic               ovr_reg,      ovr_next;
    logic [7:0]         opcode_reg,   opcode_next;
    logic [7:0]         modrm_reg,    modrm_next;
    logic [31:0]        tail_reg,     tail_next;
    logic [COUNT_W-1:0] count_reg,    count_next;
    status_t            err_reg,      err_next;
    logic [2:0]         after_reg,    after_next;

    // Result register
    logic               result_valid_reg, result_valid_next;
    out_beat_t          result_reg,       result_next;

    logic               accept;
    logic               finish;
    status_t            st;
    logic [2:0]         len;

    assign item_ready   = !result_valid_reg || result_ready;
    assign accept       = item_valid && item_ready;
    assign finish       = accept && item.last_byte;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Per-byte parser update
    always_comb
    begin
        phase_next  = phase_reg;
        ovr_next    = ovr_reg;
        opcode_next = opcode_reg;
        modrm_next  = modrm_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        err_next    = err_reg;
        after_next  = after_reg;

        if (count_reg >= COUNT_W'(MAX_INSTR_BYTES))
        begin
            if (err_reg == ST_OK)
                err_next = ST_LENGTH;
        end
        else
        begin
            count_next = count_reg + 1'b1;
        end

        if (err_next == ST_OK)
        begin
            unique case (phase_reg)
                PH_PREFIX:
                begin
                    if (is_skip_byte(item.instr_byte))
                    begin
                        if (item.instr_byte == PFX_OPSIZE)
                            ovr_next = 1'b1;
                    end
                    else
                    begin
                        opcode_next = item.instr_byte;
                        phase_next  = PH_MODRM;
                        if (item.instr_byte == OPC_ESCAPE)
                            err_next = ST_TWO_BYTE;
                        else if (!is_reg_form(item.instr_byte) &&
                                 !is_imm_form(item.instr_byte))
                            err_next = ST_UNSUPPORTED;
                    end
                end
                PH_MODRM:
                begin
                    modrm_next = item.instr_byte;
                    phase_next = PH_TAIL;
                end
                PH_TAIL:
                begin
                    tail_next = {item.instr_byte, tail_reg[31:8]};
                    if (after_reg != 3'd7)
                        after_next = after_reg + 3'd1;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Result on the last byte, from the updated state
    always_comb
    begin
        st          = err_next;
        result_next = '0;

        if (st == ST_OK)
        begin
            if (phase_next == PH_PREFIX)
                st = ST_NO_OPCODE;
            else if (phase_next == PH_MODRM)
                st = ST_LENGTH;
        end

        if (ovr_next)
            len = LEN_WORD;
        else if (opcode_next[0])
            len = LEN_DWORD;
        else
            len = LEN_BYTE;

        if (st == ST_OK)
        begin
            if (is_reg_form(opcode_next))
            begin
                result_next.dest_register =
                    $signed({1'b0, 3'((modrm_next & MODRM_REG_MASK) >> 3)});
                result_next.operand_bytes = len;
            end
            else if (after_next < len)
            begin
                st = ST_LENGTH;
            end
            else
            begin
                result_next.dest_register = REG_IMMEDIATE;
                result_next.operand_bytes = len;
                unique case (len)
                    LEN_DWORD: result_next.immediate_value = tail_next;
                    LEN_WORD:  result_next.immediate_value = {16'd0, tail_next[31:16]};
                    default:   result_next.immediate_value = {24'd0, tail_next[31:24]};
                endcase
            end
        end

        if (st != ST_OK)
        begin
            result_next.dest_register   = '0;
            result_next.operand_bytes   = '0;
            result_next.immediate_value = '0;
        end
        result_next.status = st;
    end

    // Output handshake
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (finish)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    // Parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PREFIX;
            ovr_reg    <= 1'b0;
            opcode_reg <= '0;
            modrm_reg  <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            err_reg    <= ST_OK;
            after_reg  <= '0;
        end
        else if (finish)
        begin
            phase_reg  <= PH_PREFIX;
            ovr_reg    <= 1'b0;
            opcode_reg <= '0;
            modrm_reg  <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            err_reg    <= ST_OK;
            after_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            ovr_reg    <= ovr_next;
            opcode_reg <= opcode_next;
            modrm_reg  <= modrm_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            err_reg    <= err_next;
            after_reg  <= after_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        if (finish)
            result_reg <= result_next;
    end

    // Checks
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != ST_OK) |->
            (result.dest_register == 4'sd0) && (result.operand_bytes == 3'd0) &&
            (result.immediate_value == 32'd0))
        else $error("error result carries nonzero fields");

    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_OK) |->
            (result.operand_bytes == LEN_BYTE) || (result.operand_bytes == LEN_WORD) ||
            (result.operand_bytes == LEN_DWORD))
        else $error("ok result with bad operand length");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (phase_reg == PH_PREFIX) && (count_reg == '0) && (err_reg == ST_OK)
                   && result_valid)
        else $error("parser not restarted after last byte");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_INSTR_BYTES))
        else $error("byte count beyond maximum");

    a_tail_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (after_reg != 3'd0) |-> (phase_reg == PH_TAIL))
        else $error("trailing bytes counted outside tail phase");

endmodule

`default_nettype wire
